FILE: hdl/swd_packet_master_core_assert.svh
// Assertion macros shared by the serial-wire debug master RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef SWD_PACKET_MASTER_CORE_ASSERT_SVH
`define SWD_PACKET_MASTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SWDPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SWDPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWDPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define SWDPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/swdpm_pkg.sv
// Package for the serial-wire debug master: phase, op, ack and status codes,
// the per-tick result type and the request byte builder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swdpm_pkg;

  localparam int BC_W = 7;

  localparam logic [BC_W-1:0] RESET_CYCLES = 7'd64;
  localparam logic [BC_W-1:0] IDLE_CYCLES  = 7'd8;

  localparam logic [1:0] OP_IDLE = 2'd0;
  localparam logic [1:0] OP_XFER = 2'd1;
  localparam logic [1:0] OP_LRST = 2'd2;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_LEAD  = 4'd1;
  localparam logic [3:0] PH_REQ   = 4'd2;
  localparam logic [3:0] PH_TURN1 = 4'd3;
  localparam logic [3:0] PH_ACK   = 4'd4;
  localparam logic [3:0] PH_RDATA = 4'd5;
  localparam logic [3:0] PH_RPAR  = 4'd6;
  localparam logic [3:0] PH_TURN2 = 4'd7;
  localparam logic [3:0] PH_WDATA = 4'd8;
  localparam logic [3:0] PH_WPAR  = 4'd9;
  localparam logic [3:0] PH_TAIL  = 4'd10;
  localparam logic [3:0] PH_RSTH  = 4'd11;
  localparam logic [3:0] PH_RSTL  = 4'd12;

  localparam logic [2:0] ACK_OK    = 3'h1;
  localparam logic [2:0] ACK_WAIT  = 3'h2;
  localparam logic [2:0] ACK_FAULT = 3'h4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_FAULT   = 2'd2;
  localparam logic [1:0] ST_WIRE    = 2'd3;

  localparam logic [7:0] RETRY_DEFAULT = 8'd255;

  typedef struct packed {
    logic        swclk_pulse;
    logic        swdio_out;
    logic        swdio_oe;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [31:0] rd_word;
  } swdpm_res_t;

  // Start bit, APnDP, RnW, A[3:2], even parity, stop bit, park bit (LSB first).
  function automatic logic [7:0] make_request(input logic [3:0] addr);
    make_request = {1'b1, 1'b0, ^addr, addr, 1'b1};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/swdpm_in_if.sv
// Input channel of the serial-wire debug master: valid/ready plus one tick's
// request fields. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface swdpm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  req_addr;
  logic [31:0] wr_word;
  logic        swdio_in;

  modport source (output valid, output op, output req_addr, output wr_word,
                  output swdio_in, input ready);
  modport sink (input valid, input op, input req_addr, input wr_word,
                input swdio_in, output ready);
endinterface

`default_nettype wire

FILE: hdl/swdpm_out_if.sv
// Result channel of the serial-wire debug master: valid/ready plus the
// line levels and status of one tick. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface swdpm_out_if;
  logic        valid;
  logic        ready;
  logic        swclk_pulse;
  logic        swdio_out;
  logic        swdio_oe;
  logic        busy_res;
  logic        done_res;
  logic [1:0]  status;
  logic [31:0] rd_word;

  modport source (output valid, output swclk_pulse, output swdio_out,
                  output swdio_oe, output busy_res, output done_res,
                  output status, output rd_word, input ready);
  modport sink (input valid, input swclk_pulse, input swdio_out,
                input swdio_oe, input busy_res, input done_res,
                input status, input rd_word, output ready);
endinterface

`default_nettype wire

FILE: hdl/swdpm_seq.sv
// Packet sequencer: phase state, shift registers and retry counting, one
// SWCLK period per step. Depends on swdpm_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

`include "swd_packet_master_core_assert.svh"

module swdpm_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [1:0]          op,
  input  wire logic [3:0]          req_addr,
  input  wire logic [31:0]         wr_word,
  input  wire logic                swdio_in,
  input  wire logic [7:0]          retry_limit,
  output swdpm_pkg::swdpm_res_t    res_o
);

  logic [3:0]                  phase_r, phase_nxt;
  logic [swdpm_pkg::BC_W-1:0]  bit_count_r, bit_count_nxt;
  logic [7:0]                  request_r, request_nxt;
  logic [31:0]                 data_r, data_nxt;
  logic [7:0]                  attempts_r, attempts_nxt;
  logic [2:0]                  ack_r, ack_nxt;
  logic                        parity_r, parity_nxt;
  logic [1:0]                  status_r, status_nxt;
  logic [1:0]                  pending_r, pending_nxt;
  logic [31:0]                 read_word_r, read_word_nxt;

  always_comb begin
    logic [3:0] ph;
    logic       dout;
    logic       oe;
    logic       busy;
    logic       done;
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    request_nxt   = request_r;
    data_nxt      = data_r;
    attempts_nxt  = attempts_r;
    ack_nxt       = ack_r;
    parity_nxt    = parity_r;
    status_nxt    = status_r;
    pending_nxt   = pending_r;
    read_word_nxt = read_word_r;
    dout          = 1'b0;
    oe            = 1'b1;
    done          = 1'b0;
    ph            = phase_r;

    // A start op is only honored from idle; the first tick of the new
    // sequence is executed in the same period.
    if (phase_r == swdpm_pkg::PH_IDLE) begin
      if (op == swdpm_pkg::OP_XFER) begin
        request_nxt  = swdpm_pkg::make_request(req_addr);
        data_nxt     = wr_word;
        attempts_nxt = (retry_limit != 8'd0) ? retry_limit : swdpm_pkg::RETRY_DEFAULT;
        ph           = swdpm_pkg::PH_LEAD;
      end else if (op == swdpm_pkg::OP_LRST) begin
        bit_count_nxt = swdpm_pkg::RESET_CYCLES;
        ph            = swdpm_pkg::PH_RSTH;
      end
    end
    busy      = (ph != swdpm_pkg::PH_IDLE);
    phase_nxt = ph;

    unique case (ph)
      swdpm_pkg::PH_IDLE: begin
        phase_nxt = swdpm_pkg::PH_IDLE;
      end
      swdpm_pkg::PH_LEAD: begin
        bit_count_nxt = '0;
        phase_nxt     = swdpm_pkg::PH_REQ;
      end
      swdpm_pkg::PH_REQ: begin
        dout = request_nxt[bit_count_r[2:0]];
        if (bit_count_r >= 7'd7) begin
          phase_nxt = swdpm_pkg::PH_TURN1;
        end else begin
          bit_count_nxt = bit_count_r + 7'd1;
        end
      end
      swdpm_pkg::PH_TURN1: begin
        oe            = 1'b0;
        bit_count_nxt = '0;
        ack_nxt       = '0;
        phase_nxt     = swdpm_pkg::PH_ACK;
      end
      swdpm_pkg::PH_ACK: begin
        oe      = 1'b0;
        ack_nxt = ack_r | ({2'b00, swdio_in} << bit_count_r[1:0]);
        if (bit_count_r < 7'd2) begin
          bit_count_nxt = bit_count_r + 7'd1;
        end else if (ack_nxt == swdpm_pkg::ACK_WAIT) begin
          attempts_nxt = attempts_r - 8'd1;
          if (attempts_nxt != 8'd0) begin
            phase_nxt = swdpm_pkg::PH_LEAD;
          end else begin
            pending_nxt = swdpm_pkg::ST_TIMEOUT;
            phase_nxt   = swdpm_pkg::PH_TAIL;
          end
        end else if (ack_nxt == swdpm_pkg::ACK_OK) begin
          bit_count_nxt = '0;
          parity_nxt    = 1'b0;
          phase_nxt     = request_r[2] ? swdpm_pkg::PH_RDATA : swdpm_pkg::PH_TURN2;
        end else begin
          pending_nxt = (ack_nxt == swdpm_pkg::ACK_FAULT) ? swdpm_pkg::ST_FAULT
                                                          : swdpm_pkg::ST_WIRE;
          phase_nxt   = swdpm_pkg::PH_TAIL;
        end
      end
      swdpm_pkg::PH_RDATA: begin
        oe         = 1'b0;
        data_nxt   = {swdio_in, data_r[31:1]};
        parity_nxt = parity_r ^ swdio_in;
        if (bit_count_r >= 7'd31) begin
          phase_nxt = swdpm_pkg::PH_RPAR;
        end else begin
          bit_count_nxt = bit_count_r + 7'd1;
        end
      end
      swdpm_pkg::PH_RPAR: begin
        oe            = 1'b0;
        read_word_nxt = data_r;
        pending_nxt   = (swdio_in != parity_r) ? swdpm_pkg::ST_WIRE : swdpm_pkg::ST_OK;
        phase_nxt     = swdpm_pkg::PH_TAIL;
      end
      swdpm_pkg::PH_TURN2: begin
        oe            = 1'b0;
        bit_count_nxt = '0;
        parity_nxt    = 1'b0;
        phase_nxt     = swdpm_pkg::PH_WDATA;
      end
      swdpm_pkg::PH_WDATA: begin
        dout       = data_r[0];
        parity_nxt = parity_r ^ data_r[0];
        data_nxt   = {1'b0, data_r[31:1]};
        if (bit_count_r >= 7'd31) begin
          phase_nxt = swdpm_pkg::PH_WPAR;
        end else begin
          bit_count_nxt = bit_count_r + 7'd1;
        end
      end
      swdpm_pkg::PH_WPAR: begin
        dout        = parity_r;
        pending_nxt = swdpm_pkg::ST_OK;
        phase_nxt   = swdpm_pkg::PH_TAIL;
      end
      swdpm_pkg::PH_TAIL: begin
        done       = 1'b1;
        status_nxt = pending_r;
        phase_nxt  = swdpm_pkg::PH_IDLE;
      end
      swdpm_pkg::PH_RSTH: begin
        dout = 1'b1;
        if (bit_count_nxt <= 7'd1) begin
          bit_count_nxt = swdpm_pkg::IDLE_CYCLES;
          phase_nxt     = swdpm_pkg::PH_RSTL;
        end else begin
          bit_count_nxt = bit_count_nxt - 7'd1;
        end
      end
      swdpm_pkg::PH_RSTL: begin
        if (bit_count_r <= 7'd1) begin
          bit_count_nxt = '0;
          done          = 1'b1;
          phase_nxt     = swdpm_pkg::PH_IDLE;
        end else begin
          bit_count_nxt = bit_count_r - 7'd1;
        end
      end
      default: begin
        phase_nxt = swdpm_pkg::PH_IDLE;
      end
    endcase

    res_o.swclk_pulse = busy;
    res_o.swdio_out   = dout & oe;
    res_o.swdio_oe    = oe;
    res_o.busy_res    = busy;
    res_o.done_res    = done;
    res_o.status      = status_nxt;
    res_o.rd_word     = read_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= swdpm_pkg::PH_IDLE;
      bit_count_r <= '0;
      request_r   <= '0;
      data_r      <= '0;
      attempts_r  <= '0;
      ack_r       <= '0;
      parity_r    <= 1'b0;
      status_r    <= swdpm_pkg::ST_OK;
      pending_r   <= swdpm_pkg::ST_OK;
      read_word_r <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      request_r   <= request_nxt;
      data_r      <= data_nxt;
      attempts_r  <= attempts_nxt;
      ack_r       <= ack_nxt;
      parity_r    <= parity_nxt;
      status_r    <= status_nxt;
      pending_r   <= pending_nxt;
      read_word_r <= read_word_nxt;
    end
  end

  `SWDPM_ASSERT_NEXT(a_done_to_idle, clk, rst_n, step && res_o.done_res, phase_r == swdpm_pkg::PH_IDLE, "sequence did not return to idle after its final tick")
  `SWDPM_ASSERT_NEXT(a_busy_holds, clk, rst_n, step && res_o.busy_res && !res_o.done_res, phase_r != swdpm_pkg::PH_IDLE, "sequence dropped to idle before its final tick")
  `SWDPM_ASSERT_IMPLY(a_attempts_live, clk, rst_n, phase_r == swdpm_pkg::PH_REQ, attempts_r != 8'd0, "request phase entered with no attempts left")

endmodule

`default_nettype wire

FILE: hdl/swd_packet_master_core.sv
// Serial-wire debug master top level: one SWCLK period per transaction.
// Latency: a result is valid the cycle after its input transaction is accepted.
// Throughput: one transaction per clock unless stalled; the output register
// lets a new input be taken in the same cycle the pending result is taken.
// Reset (rst_n low, synchronous): sequencer idle, retry limit 255, no result.
// Depends on swdpm_pkg, swdpm_in_if, swdpm_out_if, swdpm_seq, assertion header.
`timescale 1ns / 1ps
`default_nettype none

`include "swd_packet_master_core_assert.svh"

module swd_packet_master_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  swdpm_in_if.sink         in_if,
  swdpm_out_if.source      out_if,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  logic [7:0]            retry_limit_r;
  logic                  out_valid_r;
  swdpm_pkg::swdpm_res_t out_data_r;
  swdpm_pkg::swdpm_res_t step_res;
  logic                  in_fire;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  swdpm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_fire),
    .op          (in_if.op),
    .req_addr    (in_if.req_addr),
    .wr_word     (in_if.wr_word),
    .swdio_in    (in_if.swdio_in),
    .retry_limit (retry_limit_r),
    .res_o       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= swdpm_pkg::RETRY_DEFAULT;
    end else if (cfg_we) begin
      retry_limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= step_res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.swclk_pulse = out_data_r.swclk_pulse;
  assign out_if.swdio_out   = out_data_r.swdio_out;
  assign out_if.swdio_oe    = out_data_r.swdio_oe;
  assign out_if.busy_res    = out_data_r.busy_res;
  assign out_if.done_res    = out_data_r.done_res;
  assign out_if.status      = out_data_r.status;
  assign out_if.rd_word     = out_data_r.rd_word;

  `SWDPM_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, in_fire, out_valid_r, "accepted transaction produced no result")
  `SWDPM_ASSERT_NEXT(a_stall_keeps_result, clk, rst_n, out_valid_r && !out_if.ready, out_valid_r && $stable(out_data_r), "pending result lost while stalled")
  `SWDPM_ASSERT_IMPLY(a_no_overrun, clk, rst_n, out_valid_r && !out_if.ready, !in_if.ready, "input taken while result register full")

endmodule

`default_nettype wire

FILE: tb/sv/swd_tick_checker.sv
// Result checker for the serial-wire debug master: watches both channels,
// predicts every tick and compares it with the block's result.
// Depends on swdpm_pkg, swdpm_in_if and swdpm_out_if.
`timescale 1ns / 1ps

module swd_tick_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  swdpm_in_if             mon_in,
  swdpm_out_if            mon_out,
  output int              fail_cnt,
  output int              pending_cnt,
  output logic            seq_idle
);
  import swdpm_pkg::*;

  // Shadow copy of the host sequencer.
  logic [7:0]  limit_q;
  logic [3:0]  ph;
  logic [6:0]  bits;
  logic [7:0]  req_q;
  logic [31:0] shift_q;
  logic [7:0]  tries_left;
  logic [2:0]  ack_q;
  logic        par_q;
  logic [1:0]  last_st;
  logic [1:0]  pend_st;
  logic [31:0] rd_word_q;

  swdpm_res_t expected_ticks[$];

  initial begin
    fail_cnt = 0;
    pending_cnt = 0;
    seq_idle = 1'b1;
  end

  task automatic step_swd_host(input logic [1:0] op, input logic [3:0] addr,
                               input logic [31:0] wd, input logic din,
                               output swdpm_res_t r);
    r = '0;
    r.swdio_oe = 1'b1;
    if (ph == PH_IDLE) begin
      if (op == OP_XFER) begin
        // Start and park bits set, address in bits 4:1, even parity in bit 5.
        req_q = 8'h81 | {2'b00, ^addr, addr, 1'b0};
        shift_q = wd;
        tries_left = (limit_q == 8'd0) ? RETRY_DEFAULT : limit_q;
        ph = PH_LEAD;
      end else if (op == OP_LRST) begin
        bits = RESET_CYCLES;
        ph = PH_RSTH;
      end
    end
    if (ph != PH_IDLE) begin
      r.swclk_pulse = 1'b1;
      r.busy_res = 1'b1;
    end
    case (ph)
      PH_LEAD: begin
        bits = '0;
        ph = PH_REQ;
      end
      PH_REQ: begin
        r.swdio_out = req_q[bits[2:0]];
        if (bits >= 7) ph = PH_TURN1;
        else bits = bits + 7'd1;
      end
      PH_TURN1: begin
        r.swdio_oe = 1'b0;
        bits = '0;
        ack_q = '0;
        ph = PH_ACK;
      end
      PH_ACK: begin
        r.swdio_oe = 1'b0;
        ack_q[bits[1:0]] = ack_q[bits[1:0]] | din;
        if (bits < 2) begin
          bits = bits + 7'd1;
        end else if (ack_q == ACK_WAIT) begin
          tries_left = tries_left - 8'd1;
          if (tries_left != 8'd0) begin
            ph = PH_LEAD;
          end else begin
            pend_st = ST_TIMEOUT;
            ph = PH_TAIL;
          end
        end else if (ack_q == ACK_OK) begin
          bits = '0;
          par_q = 1'b0;
          ph = req_q[2] ? PH_RDATA : PH_TURN2;
        end else begin
          pend_st = (ack_q == ACK_FAULT) ? ST_FAULT : ST_WIRE;
          ph = PH_TAIL;
        end
      end
      PH_RDATA: begin
        r.swdio_oe = 1'b0;
        shift_q = {din, shift_q[31:1]};
        par_q = par_q ^ din;
        if (bits >= 31) ph = PH_RPAR;
        else bits = bits + 7'd1;
      end
      PH_RPAR: begin
        r.swdio_oe = 1'b0;
        rd_word_q = shift_q;
        pend_st = (din != par_q) ? ST_WIRE : ST_OK;
        ph = PH_TAIL;
      end
      PH_TURN2: begin
        r.swdio_oe = 1'b0;
        bits = '0;
        par_q = 1'b0;
        ph = PH_WDATA;
      end
      PH_WDATA: begin
        r.swdio_out = shift_q[0];
        par_q = par_q ^ shift_q[0];
        shift_q = shift_q >> 1;
        if (bits >= 31) ph = PH_WPAR;
        else bits = bits + 7'd1;
      end
      PH_WPAR: begin
        r.swdio_out = par_q;
        pend_st = ST_OK;
        ph = PH_TAIL;
      end
      PH_TAIL: begin
        r.done_res = 1'b1;
        last_st = pend_st;
        ph = PH_IDLE;
      end
      PH_RSTH: begin
        r.swdio_out = 1'b1;
        if (bits <= 1) begin
          bits = IDLE_CYCLES;
          ph = PH_RSTL;
        end else begin
          bits = bits - 7'd1;
        end
      end
      PH_RSTL: begin
        if (bits <= 1) begin
          bits = '0;
          r.done_res = 1'b1;
          ph = PH_IDLE;
        end else begin
          bits = bits - 7'd1;
        end
      end
      default: ph = PH_IDLE;
    endcase
    if (!r.swdio_oe) r.swdio_out = 1'b0;
    r.status = last_st;
    r.rd_word = rd_word_q;
  endtask

  always @(posedge clk) begin : watch
    swdpm_res_t want;
    swdpm_res_t seen;
    if (!rst_n) begin
      limit_q = RETRY_DEFAULT;
      ph = PH_IDLE;
      bits = '0;
      req_q = '0;
      shift_q = '0;
      tries_left = '0;
      ack_q = '0;
      par_q = 1'b0;
      last_st = ST_OK;
      pend_st = ST_OK;
      rd_word_q = '0;
      expected_ticks.delete();
    end else begin
      // The result taken at this edge belongs to an earlier transaction, so it
      // is checked before the input taken at the same edge is predicted.
      if (mon_out.valid === 1'b1 && mon_out.ready === 1'b1) begin
        seen = {mon_out.swclk_pulse, mon_out.swdio_out, mon_out.swdio_oe,
                mon_out.busy_res, mon_out.done_res, mon_out.status,
                mon_out.rd_word};
        if (expected_ticks.size() == 0) begin
          if (fail_cnt < 10)
            $display("[%0t] unexpected result transaction: %h", $realtime, seen);
          fail_cnt++;
        end else begin
          want = expected_ticks.pop_front();
          if (seen.swclk_pulse !== want.swclk_pulse || seen.swdio_out !== want.swdio_out ||
              seen.swdio_oe !== want.swdio_oe || seen.busy_res !== want.busy_res ||
              seen.done_res !== want.done_res || seen.status !== want.status ||
              seen.rd_word !== want.rd_word) begin
            if (fail_cnt < 10) begin
              $display("[%0t] mismatch: expected clk=%b out=%b oe=%b busy=%b done=%b st=%0d rd=%h",
                       $realtime, want.swclk_pulse, want.swdio_out, want.swdio_oe,
                       want.busy_res, want.done_res, want.status, want.rd_word);
              $display("[%0t]           actual clk=%b out=%b oe=%b busy=%b done=%b st=%0d rd=%h",
                       $realtime, seen.swclk_pulse, seen.swdio_out, seen.swdio_oe,
                       seen.busy_res, seen.done_res, seen.status, seen.rd_word);
            end
            fail_cnt++;
          end
        end
      end
      if (mon_in.valid === 1'b1 && mon_in.ready === 1'b1) begin
        step_swd_host(mon_in.op, mon_in.req_addr, mon_in.wr_word, mon_in.swdio_in, want);
        expected_ticks.push_back(want);
      end
      // A register write at this edge only affects later transactions.
      if (cfg_we) limit_q = cfg_wdata;
    end
    pending_cnt <= expected_ticks.size();
    seq_idle <= (ph == PH_IDLE);
  end

endmodule

FILE: tb/sv/tb_swd_packet_master_core.sv
// Top of the serial-wire debug master testbench: clock, reset, register writes,
// packet-shaped stimulus and the verdict. Depends on swdpm_pkg, the channel
// interfaces, swd_packet_master_core and swd_tick_checker.
`timescale 1ns / 1ps

module tb_swd_packet_master_core;
  import swdpm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] ACK_NONE  = 3'b000;
  localparam logic [2:0] ACK_JUNK  = 3'b111;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int   fail_cnt;
  int   pending_cnt;
  logic seq_idle;

  bit rx_hold_req;
  int rx_hold_len;
  int burst_left;
  int cur_limit;
  int sent_cnt;

  swdpm_in_if  in_if ();
  swdpm_out_if out_if ();

  swd_packet_master_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  swd_tick_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mon_in      (in_if),
    .mon_out     (out_if),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt),
    .seq_idle    (seq_idle)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(64'd2_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stall patterns, plus a long hold-off when requested.
  initial begin : result_sink
    int mode;
    int stretch;
    int k;
    stretch = 0;
    mode = 0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        for (k = 0; k < rx_hold_len; k++) begin
          out_if.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 3);
          stretch = $urandom_range(5, 80);
        end
        stretch--;
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 9) != 0);
          default: out_if.ready <= ((stretch % 7) < 4);
        endcase
        @(posedge clk);
      end
    end
  end

  // One transaction on the input channel; the sender works in bursts.
  task automatic send_tick(input logic [1:0] op, input logic [3:0] addr,
                           input logic [31:0] wd, input logic din);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 20);
    end
    in_if.valid    <= 1'b1;
    in_if.op       <= op;
    in_if.req_addr <= addr;
    in_if.wr_word  <= wd;
    in_if.swdio_in <= din;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    burst_left--;
    sent_cnt++;
  endtask

  // Tick while the sequencer is busy: the op is usually idle, sometimes any code.
  task automatic busy_tick(input logic din);
    logic [1:0] op;
    op = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : OP_IDLE;
    send_tick(op, 4'($urandom), $urandom, din);
  endtask

  // Idle ticks until the sequencer was idle before the last one.
  task automatic settle();
    do send_tick($urandom_range(0, 1) ? OP_IDLE : OP_UNUSED, 4'($urandom), $urandom,
                 1'($urandom));
    while (!seq_idle);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0 || !seq_idle) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_limit = (v == 8'd0) ? 255 : v;
  endtask

  // A complete transfer: n_wait WAIT answers, then final_ack, then the data
  // phase when the answer is OK. Stops early when the attempts run out.
  task automatic do_transfer(input logic [3:0] addr, input logic [31:0] wd,
                             input int n_wait, input logic [2:0] final_ack,
                             input logic [31:0] rd_word, input logic bad_par);
    int a;
    int i;
    logic [2:0] ack;
    send_tick(OP_XFER, addr, wd, 1'($urandom));
    a = 0;
    while (1) begin
      if (a > 0) busy_tick(1'($urandom));
      repeat (9) busy_tick(1'($urandom));
      ack = (a < n_wait) ? ACK_WAIT : final_ack;
      for (i = 0; i < 3; i++) busy_tick(ack[i]);
      a++;
      if (ack != ACK_WAIT || a >= cur_limit) break;
    end
    if (ack == ACK_OK) begin
      if (addr[1]) begin
        for (i = 0; i < 32; i++) busy_tick(rd_word[i]);
        busy_tick(^rd_word ^ bad_par);
      end else begin
        repeat (34) busy_tick(1'($urandom));
      end
    end
    busy_tick(1'($urandom));
  endtask

  task automatic line_reset();
    send_tick(OP_LRST, 4'($urandom), $urandom, 1'($urandom));
    repeat (71) busy_tick(1'($urandom));
  endtask

  // Fully random transactions, then back to idle.
  task automatic noise_run(input int n);
    repeat (n) send_tick(2'($urandom), 4'($urandom), $urandom, 1'($urandom));
    settle();
  endtask

  initial begin : stimulus
    int seq_idx;
    int pick;
    int n_wait;
    logic [2:0] odd_ack;
    rx_hold_req = 1'b0;
    rx_hold_len = 0;
    burst_left = 0;
    cur_limit = 255;
    sent_cnt = 0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 8'd0;
    in_if.valid    <= 1'b0;
    in_if.op       <= OP_IDLE;
    in_if.req_addr <= 4'd0;
    in_if.wr_word  <= 32'd0;
    in_if.swdio_in <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    send_tick(OP_IDLE, 4'h0, 32'h0000_0000, 1'b0);
    send_tick(OP_UNUSED, 4'hF, 32'hFFFF_FFFF, 1'b1);
    do_transfer(4'h0, 32'hFFFF_FFFF, 0, ACK_OK, 32'h0, 1'b0);
    do_transfer(4'h6, 32'h0, 0, ACK_OK, 32'hA5C3_0F91, 1'b1);
    do_transfer(4'h5, 32'h1234_5678, 0, ACK_FAULT, 32'h0, 1'b0);
    line_reset();
    do_transfer(4'h9, 32'h0, 0, ACK_NONE, 32'h0, 1'b0);
    do_transfer(4'hA, 32'h0, 1, ACK_JUNK, 32'h0, 1'b0);
    write_limit(8'd1);
    do_transfer(4'h3, 32'h0, 1, ACK_OK, 32'h0, 1'b0);
    write_limit(8'd0);
    do_transfer(4'hE, 32'h0, 2, ACK_FAULT, 32'h0, 1'b0);
    write_limit(8'd255);
    noise_run(10);

    // Random part: mostly well-formed transfers with random content, until
    // about 400 transactions have gone in.
    seq_idx = 0;
    while (sent_cnt < 400) begin
      // The receiver holds off while the sender keeps offering transactions.
      if (seq_idx == 0) begin
        rx_hold_len = 300;
        rx_hold_req = 1'b1;
      end
      if (seq_idx == 1) begin
        case ($urandom_range(0, 5))
          0: write_limit(8'd0);
          1: write_limit(8'd1);
          2: write_limit(8'd255);
          3: write_limit(8'($urandom_range(2, 4)));
          default: write_limit(8'($urandom_range(1, 255)));
        endcase
      end
      if (seq_idx == 2) wait_drained();
      pick = $urandom_range(0, 99);
      n_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (cur_limit <= 8 && $urandom_range(0, 4) == 0) n_wait = cur_limit;
      if (pick < 70) begin
        do_transfer(4'($urandom), $urandom, n_wait, ACK_OK, $urandom, 1'b0);
      end else if (pick < 80) begin
        case ($urandom_range(0, 3))
          0: odd_ack = ACK_FAULT;
          1: odd_ack = ACK_NONE;
          2: odd_ack = ACK_JUNK;
          default: odd_ack = ($urandom_range(0, 1) == 0) ? 3'b011 : 3'b101;
        endcase
        do_transfer(4'($urandom), $urandom, n_wait, odd_ack, $urandom, 1'b0);
      end else if (pick < 85) begin
        do_transfer({2'($urandom), 1'b1, 1'($urandom)}, $urandom, n_wait, ACK_OK,
                    $urandom, 1'b1);
      end else if (pick < 90) begin
        line_reset();
      end else begin
        noise_run($urandom_range(1, 20));
      end
      seq_idx++;
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/swdpm_pkg.sv
hdl/swdpm_in_if.sv
hdl/swdpm_out_if.sv
hdl/swdpm_seq.sv
hdl/swd_packet_master_core.sv
tb/sv/swd_tick_checker.sv
tb/sv/tb_swd_packet_master_core.sv
